// ----- rtl/qph_pkg.sv -----
// Shared constants, codes and types of the quadratic probe hash table.
package qph_pkg;

  localparam int KEY_WIDTH  = 16;
  localparam int IDX_W      = 7;
  localparam int TABLE_SIZE = 1 << IDX_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    TAG_EMPTY   = 2'd0,
    TAG_USED    = 2'd1,
    TAG_DELETED = 2'd2
  } tag_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t                  func;
    logic [KEY_WIDTH-1:0] key;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot_index;
  } rsp_t;

  // One table entry as held in the slot memory.
  typedef struct packed {
    tag_t                 tag;
    logic [KEY_WIDTH-1:0] key;
  } ent_t;

  typedef struct packed {
    logic             start;
    logic             step;
    logic [IDX_W-1:0] home;
  } probe_ctrl_t;

endpackage

// ----- rtl/qph_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module qph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/qph_probe.sv -----
// Quadratic probe address generator: slot, odd stride and probe count.
module qph_probe
  import qph_pkg::*;
(
  input  logic             clk,
  input  probe_ctrl_t      ctrl,
  output logic [IDX_W-1:0] rd_addr,
  output logic [IDX_W-1:0] slot,
  output logic             last
);

  // i*i grows by 2i+1 from one probe to the next; sums wrap at the table size.
  logic [IDX_W-1:0] stride;
  logic [IDX_W-1:0] count;

  assign rd_addr = ctrl.start ? ctrl.home : IDX_W'(slot + stride);
  assign last    = (count == IDX_W'(TABLE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      slot   <= ctrl.home;
      stride <= IDX_W'(1);
      count  <= '0;
    end else if (ctrl.step) begin
      slot   <= IDX_W'(slot + stride);
      stride <= IDX_W'(stride + IDX_W'(2));
      count  <= IDX_W'(count + IDX_W'(1));
    end
  end

endmodule

// ----- rtl/quadratic_probe_hash_table.sv -----
// Top level of the quadratic probe hash table: control, slot memory and result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   req     | in        | req_valid/req_ready  | req_t: func, key
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_t: status, slot_index
//
// An operation is accepted in the idle state, runs P probes (1 to TABLE_SIZE),
// each a read through the single read port of the slot memory, and ends in
// the finish state, which waits for a free output register. An unused func
// code skips the probes. Reset clears the slot tags at once through one valid
// flop per slot; no clearing pass runs. A stalled result sits in the output
// register while the next request is already taken and probed.
module quadratic_probe_hash_table
  import qph_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  state_t state;
  state_t state_next;

  op_t                  func_r;
  logic [KEY_WIDTH-1:0] key_r;
  rsp_t                 pend;
  logic                 slot_valid [TABLE_SIZE];

  // Probe and memory control.
  probe_ctrl_t          pctrl;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     slot;
  logic                 last;
  logic                 re;
  logic                 we;
  ent_t                 wr_ent;
  logic [$bits(ent_t)-1:0] rd_raw;
  ent_t                 rd_ent;
  tag_t                 tag_now;
  logic                 key_hit;

  // Decision of the current probe.
  logic                 done;
  rsp_t                 res;

  logic req_xfer;
  logic rsp_free;

  assign req_ready = (state == S_IDLE);
  assign req_xfer  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  qph_probe u_probe (
    .clk     (clk),
    .ctrl    (pctrl),
    .rd_addr (rd_addr),
    .slot    (slot),
    .last    (last)
  );

  qph_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (we),
    .waddr (slot),
    .wdata (wr_ent),
    .re    (re),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  assign rd_ent = ent_t'(rd_raw);
  // A slot never written since reset reads as empty.
  assign tag_now = slot_valid[slot] ? rd_ent.tag : TAG_EMPTY;
  assign key_hit = (rd_ent.key == key_r);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.func == OP_INSERT || req.func == OP_SEARCH || req.func == OP_REMOVE) begin
            state_next = S_PROBE;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        if (done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: probe control, memory access and the probe decision.
  always_comb begin
    pctrl      = '0;
    re         = 1'b0;
    we         = 1'b0;
    wr_ent.tag = TAG_USED;
    wr_ent.key = key_r;
    done       = 1'b0;
    res.status = ST_MISS;
    res.slot_index = '0;
    unique case (state)
      S_IDLE: begin
        // Read the home slot in the same cycle as the transfer.
        pctrl.home = req.key[IDX_W-1:0];
        if (req_valid) begin
          pctrl.start = 1'b1;
          re          = 1'b1;
        end
      end
      S_PROBE: begin
        case (func_r) inside
          OP_INSERT: begin
            if (tag_now != TAG_USED) begin
              done       = 1'b1;
              we         = 1'b1;
              res.status = ST_DONE;
              res.slot_index = slot;
            end else if (key_hit) begin
              done       = 1'b1;
              res.status = ST_DUP;
              res.slot_index = slot;
            end else if (last) begin
              done       = 1'b1;
              res.status = ST_FULL;
            end
          end
          OP_SEARCH, OP_REMOVE: begin
            if (tag_now == TAG_EMPTY) begin
              done = 1'b1;
            end else if (tag_now == TAG_USED && key_hit) begin
              done       = 1'b1;
              res.status = ST_DONE;
              res.slot_index = slot;
              if (func_r == OP_REMOVE) begin
                // Leave a tombstone.
                we         = 1'b1;
                wr_ent.tag = TAG_DELETED;
              end
            end else if (last) begin
              done = 1'b1;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        // No verdict yet: advance to the next probe and read it.
        if (!done) begin
          pctrl.step = 1'b1;
          re         = 1'b1;
        end
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request and the pending result.
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      func_r <= req.func;
      key_r  <= req.key;
      pend.status     <= ST_MISS;
      pend.slot_index <= '0;
    end else if (state == S_PROBE && done) begin
      pend <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        slot_valid[n] <= 1'b0;
      end
    end else if (we) begin
      slot_valid[slot] <= 1'b1;
    end
  end

  // Output register: load in the finish cycle once the previous result left.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_FINISH && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && rsp_free) begin
      rsp <= pend;
    end
  end

`ifndef NO_ASSERTIONS
  // The slot memory is written only while a probe decides.
  a_write_in_probe: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_PROBE))
    else $error("slot write outside probe state");

  // The last probe always ends the operation.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && last) |=> (state != S_PROBE))
    else $error("probe ran past the table size");

  // A new result appears only out of the finish state.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    (!rsp_valid ##1 rsp_valid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside finish state");
`endif

endmodule
